FILE: hdl/pls_pkg.sv
// ----------------------------------------------------------------------------
// pls_pkg
// Shared types, codes and sizes for the positional list stack unit.
// ----------------------------------------------------------------------------
package pls_pkg;

   // default sizes handed to the top level parameters
   localparam int CAPACITY_DEF   = 64;
   localparam int DATA_WIDTH_DEF = 32;

   // fixed field widths of the stream transactions
   localparam int FUNC_W      = 3;
   localparam int POS_W       = 7;
   localparam int VAL_W       = 32;
   localparam int STATUS_W    = 2;
   localparam int COUNT_OUT_W = 7;
   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 40;

   // operation codes
   localparam logic [FUNC_W-1:0] FUNC_INSERT = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_DELETE = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_PUSH   = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_POP    = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_TOP    = 3'd4;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd2;
   localparam logic [STATUS_W-1:0] ST_FULL   = 2'd3;

   // index register update
   typedef enum logic [2:0] {
      IDX_HOLD,
      IDX_COUNT,
      IDX_POS,
      IDX_DEC,
      IDX_INC
   } idx_sel_type;

   // memory read address select
   typedef enum logic [1:0] {
      RD_PREV,
      RD_NEXT,
      RD_TOP
   } rd_sel_type;

   // controller to datapath commands
   typedef struct packed {
      logic                req_load;
      logic                status_ld;
      logic [STATUS_W-1:0] status_code;
      idx_sel_type         idx_sel;
      rd_sel_type          rd_sel;
      logic                mem_wr;
      logic                wr_put;
      logic                top_put;
      logic                top_load;
      logic                count_inc;
      logic                count_dec;
      logic                out_load;
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic              pos_gt_count;
      logic              pos_eq_count;
      logic              count_zero;
      logic              count_full;
      logic              more_up;
      logic              more_down;
      logic              out_free;
   } flag_type;

endpackage

FILE: hdl/pls_ctrl.sv
// ----------------------------------------------------------------------------
// pls_ctrl
// Controller state machine: decodes the operation, sequences the entry
// shift loops and the top refresh, and hands the result to the output stage.
// ----------------------------------------------------------------------------
module pls_ctrl
   import pls_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_tvalid,
   output logic     req_tready,
   input  flag_type flags,
   output cmd_type  cmd
);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_DECODE = 4'd1;
   localparam logic [3:0] S_UP_CHK = 4'd2;
   localparam logic [3:0] S_UP_RD  = 4'd3;
   localparam logic [3:0] S_UP_WR  = 4'd4;
   localparam logic [3:0] S_DN_CHK = 4'd5;
   localparam logic [3:0] S_DN_RD  = 4'd6;
   localparam logic [3:0] S_DN_WR  = 4'd7;
   localparam logic [3:0] S_PUT    = 4'd8;
   localparam logic [3:0] S_DEC    = 4'd9;
   localparam logic [3:0] S_TOP_RD = 4'd10;
   localparam logic [3:0] S_TOP_LD = 4'd11;
   localparam logic [3:0] S_FINISH = 4'd12;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   assign req_tready = (state_ff == S_IDLE);

   // next state and commands
   always_comb begin
      state_in        = state_ff;
      cmd             = '0;
      cmd.status_code = ST_OK;
      cmd.idx_sel     = IDX_HOLD;
      cmd.rd_sel      = RD_TOP;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.req_load = 1'b1;
               state_in     = S_DECODE;
            end
         end
         S_DECODE: begin
            cmd.status_ld = 1'b1;
            state_in      = S_FINISH;
            unique case (flags.func)
               FUNC_INSERT: begin
                  priority if (flags.pos_gt_count) begin
                     cmd.status_code = ST_BADPOS;
                  end else if (flags.count_full) begin
                     cmd.status_code = ST_FULL;
                  end else begin
                     cmd.idx_sel = IDX_COUNT;
                     state_in    = S_UP_CHK;
                  end
               end
               FUNC_DELETE: begin
                  priority if (flags.pos_gt_count) begin
                     cmd.status_code = ST_BADPOS;
                  end else if (flags.count_zero) begin
                     cmd.status_code = ST_EMPTY;
                  end else if (flags.pos_eq_count) begin
                     cmd.status_code = ST_BADPOS;
                  end else begin
                     cmd.idx_sel = IDX_POS;
                     state_in    = S_DN_CHK;
                  end
               end
               FUNC_PUSH: begin
                  if (flags.count_full) begin
                     cmd.status_code = ST_FULL;
                  end else begin
                     cmd.idx_sel = IDX_COUNT;
                     state_in    = S_PUT;
                  end
               end
               FUNC_POP: begin
                  if (flags.count_zero) begin
                     cmd.status_code = ST_EMPTY;
                  end else begin
                     state_in = S_DEC;
                  end
               end
               FUNC_TOP: begin
                  if (flags.count_zero) begin
                     cmd.status_code = ST_EMPTY;
                  end
               end
               default: begin
                  cmd.status_code = ST_OK;
               end
            endcase
         end
         // move entries up, from the tail down to the insert position
         S_UP_CHK: begin
            state_in = flags.more_up ? S_UP_RD : S_PUT;
         end
         S_UP_RD: begin
            cmd.rd_sel = RD_PREV;
            state_in   = S_UP_WR;
         end
         S_UP_WR: begin
            cmd.mem_wr  = 1'b1;
            cmd.idx_sel = IDX_DEC;
            state_in    = S_UP_CHK;
         end
         // move entries down, from the delete position to the tail
         S_DN_CHK: begin
            state_in = flags.more_down ? S_DN_RD : S_DEC;
         end
         S_DN_RD: begin
            cmd.rd_sel = RD_NEXT;
            state_in   = S_DN_WR;
         end
         S_DN_WR: begin
            cmd.mem_wr  = 1'b1;
            cmd.idx_sel = IDX_INC;
            state_in    = S_DN_CHK;
         end
         // store the new word and grow the list
         S_PUT: begin
            cmd.mem_wr    = 1'b1;
            cmd.wr_put    = 1'b1;
            cmd.top_put   = 1'b1;
            cmd.count_inc = 1'b1;
            state_in      = S_FINISH;
         end
         // shrink the list, then fetch the new last entry
         S_DEC: begin
            cmd.count_dec = 1'b1;
            state_in      = S_TOP_RD;
         end
         S_TOP_RD: begin
            cmd.rd_sel = RD_TOP;
            state_in   = S_TOP_LD;
         end
         S_TOP_LD: begin
            cmd.top_load = 1'b1;
            state_in     = S_FINISH;
         end
         S_FINISH: begin
            if (flags.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: hdl/pls_dpath.sv
// ----------------------------------------------------------------------------
// pls_dpath
// Datapath: request registers, entry memory, index, count and top registers,
// and the result output register.
// ----------------------------------------------------------------------------
module pls_dpath
   import pls_pkg::*;
#(
   parameter int CAPACITY   = CAPACITY_DEF,
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cmd_type                cmd,
   output flag_type               flags,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic [FUNC_W-1:0]      req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   output logic [STATUS_W-1:0]    rsp_tuser
);

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int AW = $clog2(CAPACITY);
   localparam int XW = (CW > POS_W) ? CW : POS_W;

   logic [DATA_WIDTH-1:0] mem [CAPACITY];

   logic [FUNC_W-1:0]      func_ff;
   logic [POS_W-1:0]       pos_ff;
   logic [DATA_WIDTH-1:0]  value_ff;
   logic [CW-1:0]          count_ff;
   logic [CW-1:0]          idx_ff;
   logic [DATA_WIDTH-1:0]  top_ff;
   logic [DATA_WIDTH-1:0]  rd_data_ff;
   logic [STATUS_W-1:0]    status_ff;
   logic                   rsp_valid_ff;
   logic [RSP_TDATA_W-1:0] rsp_tdata_ff;
   logic [STATUS_W-1:0]    rsp_tuser_ff;

   logic [XW-1:0]   pos_x;
   logic [XW-1:0]   count_x;
   logic [XW-1:0]   idx_x;
   logic [CW-1:0]   rd_idx;
   logic [63:0]     value_sx;
   logic [63:0]     top_wide;
   logic [VAL_W-1:0] top_out;

   assign pos_x   = XW'(pos_ff);
   assign count_x = XW'(count_ff);
   assign idx_x   = XW'(idx_ff);

   // status toward the controller
   always_comb begin
      flags.func         = func_ff;
      flags.pos_gt_count = (pos_x > count_x);
      flags.pos_eq_count = (pos_x == count_x);
      flags.count_zero   = (count_ff == '0);
      flags.count_full   = (count_ff == CW'(CAPACITY));
      flags.more_up      = (idx_x > pos_x);
      flags.more_down    = (({1'b0, idx_x} + (XW + 1)'(1)) < {1'b0, count_x});
      flags.out_free     = !rsp_valid_ff || rsp_tready;
   end

   // request capture, value sign-extended then sized to the entry width
   assign value_sx = {{(64 - VAL_W){req_tdata[POS_W+VAL_W-1]}}, req_tdata[POS_W+VAL_W-1:POS_W]};

   always_ff @(posedge clock) begin
      if (cmd.req_load) begin
         func_ff  <= req_tuser;
         pos_ff   <= req_tdata[POS_W-1:0];
         value_ff <= value_sx[DATA_WIDTH-1:0];
      end
      if (cmd.status_ld) begin
         status_ff <= cmd.status_code;
      end
   end

   // read address select
   always_comb begin
      unique case (cmd.rd_sel)
         RD_PREV: rd_idx = idx_ff - CW'(1);
         RD_NEXT: rd_idx = idx_ff + CW'(1);
         RD_TOP:  rd_idx = count_ff - CW'(1);
         default: rd_idx = count_ff - CW'(1);
      endcase
   end

   // entry memory, one write and one registered read a cycle
   always_ff @(posedge clock) begin
      if (cmd.mem_wr) begin
         mem[idx_ff[AW-1:0]] <= cmd.wr_put ? value_ff : rd_data_ff;
      end
      rd_data_ff <= mem[rd_idx[AW-1:0]];
   end

   // index register
   always_ff @(posedge clock) begin
      unique case (cmd.idx_sel)
         IDX_HOLD:  idx_ff <= idx_ff;
         IDX_COUNT: idx_ff <= count_ff;
         IDX_POS:   idx_ff <= CW'(pos_x);
         IDX_DEC:   idx_ff <= idx_ff - CW'(1);
         IDX_INC:   idx_ff <= idx_ff + CW'(1);
         default:   idx_ff <= idx_ff;
      endcase
   end

   // top entry tracking
   always_ff @(posedge clock) begin
      if (cmd.top_put && (idx_ff == count_ff)) begin
         top_ff <= value_ff;
      end else if (cmd.top_load) begin
         top_ff <= rd_data_ff;
      end
   end

   // entry count
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.count_inc) begin
         count_ff <= count_ff + CW'(1);
      end else if (cmd.count_dec) begin
         count_ff <= count_ff - CW'(1);
      end
   end

   // result output register
   assign top_wide = 64'(top_ff);
   assign top_out  = (count_ff == '0) ? '0 : top_wide[VAL_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_tdata_ff <= {(count_ff == '0), count_x[COUNT_OUT_W-1:0], top_out};
         rsp_tuser_ff <= status_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

endmodule

FILE: hdl/positional_list_stack_unit.sv
// ----------------------------------------------------------------------------
// positional_list_stack_unit
// Ordered list of signed words with positional insert and delete, push, pop
// and top read; one result transaction per request transaction.
// ----------------------------------------------------------------------------
// the shift loops move one entry at a time through the entry memory: check, read, then write
// one request in flight at a time; the next is taken while a result waits
// reset clears the entry count and the handshake state; the entry memory
//   is not cleared, entries above the count never reach a result
module positional_list_stack_unit
   import pls_pkg::*;
#(
   parameter int CAPACITY   = CAPACITY_DEF,
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // position[6:0], value_in[38:7], zero fill
   input  logic [FUNC_W-1:0]      req_tuser,   // func[2:0]
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // top_value[31:0], entry_count[38:32],
                                               // is_empty[39]
   output logic [STATUS_W-1:0]    rsp_tuser    // status[1:0]
);

   cmd_type  cmd;
   flag_type flags;

   // controller
   pls_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .flags      (flags),
      .cmd        (cmd)
   );

   // datapath
   pls_dpath #(
      .CAPACITY   (CAPACITY),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .flags      (flags),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stream-level test of the positional list stack unit. A scoreboard keeps its
// own copy of the list, works out the expected result of every accepted
// request and checks each response transaction field by field. Stimulus is a
// short directed pass over the corner cases, then random traffic that swings
// the list between empty and full, with random idle gaps on both sides.
// ----------------------------------------------------------------------------
module tb;
   import pls_pkg::*;

   localparam int LIST_DEPTH  = CAPACITY_DEF;
   localparam int RANDOM_OPS  = 750;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int SETTLE_CYC  = 16;

   // operation codes the block leaves unused
   localparam logic [FUNC_W-1:0] FUNC_SPARE_5 = 3'd5;
   localparam logic [FUNC_W-1:0] FUNC_SPARE_6 = 3'd6;
   localparam logic [FUNC_W-1:0] FUNC_SPARE_7 = 3'd7;

   typedef struct {
      logic [STATUS_W-1:0]    status;
      logic [VAL_W-1:0]       top_value;
      logic [COUNT_OUT_W-1:0] entry_count;
      logic                   is_empty;
   } list_result_type;

   // list model and queue of expected responses
   class list_scoreboard;
      logic [VAL_W-1:0] entries[$];
      list_result_type  expected_q[$];
      int               errors;

      function int depth();
         return entries.size();
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // apply one accepted request to the list and queue its response
      function void note_request(logic [FUNC_W-1:0] op, logic [POS_W-1:0] pos,
                                 logic [VAL_W-1:0] value);
         list_result_type res;
         int n;
         n = entries.size();
         res.status = ST_OK;
         case (op)
            FUNC_INSERT: begin
               if (pos > n) res.status = ST_BADPOS;
               else if (n >= LIST_DEPTH) res.status = ST_FULL;
               else entries.insert(pos, value);
            end
            FUNC_DELETE: begin
               if (pos > n) res.status = ST_BADPOS;
               else if (n == 0) res.status = ST_EMPTY;
               else if (pos == n) res.status = ST_BADPOS;
               else entries.delete(pos);
            end
            FUNC_PUSH: begin
               if (n >= LIST_DEPTH) res.status = ST_FULL;
               else entries.push_back(value);
            end
            FUNC_POP: begin
               if (n == 0) res.status = ST_EMPTY;
               else void'(entries.pop_back());
            end
            FUNC_TOP: begin
               if (n == 0) res.status = ST_EMPTY;
            end
            default: ;
         endcase
         n = entries.size();
         res.top_value   = (n != 0) ? entries[n-1] : '0;
         res.entry_count = n[COUNT_OUT_W-1:0];
         res.is_empty    = (n == 0);
         expected_q.push_back(res);
      endfunction

      // compare one response transaction with the oldest expectation
      function void check_response(list_result_type got);
         list_result_type want;
         if (expected_q.size() == 0) begin
            $display("%0t: response with nothing expected: status %0d top %h count %0d",
                     $time, got.status, got.top_value, got.entry_count);
            errors++;
            return;
         end
         want = expected_q.pop_front();
         if (got.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
            errors++;
         end
         if (got.top_value !== want.top_value) begin
            $display("%0t: top_value expected %h actual %h", $time, want.top_value,
                     got.top_value);
            errors++;
         end
         if (got.entry_count !== want.entry_count) begin
            $display("%0t: entry_count expected %0d actual %0d", $time, want.entry_count,
                     got.entry_count);
            errors++;
         end
         if (got.is_empty !== want.is_empty) begin
            $display("%0t: is_empty expected %b actual %b", $time, want.is_empty,
                     got.is_empty);
            errors++;
         end
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;   // position[6:0], value_in[38:7], zero fill
   logic [FUNC_W-1:0]      req_tuser = '0;   // func[2:0]
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;       // top_value[31:0], entry_count[38:32],
                                            // is_empty[39]
   logic [STATUS_W-1:0]    rsp_tuser;       // status[1:0]

   list_scoreboard list_sb = new();
   bit             calm_req;
   bit             calm_rsp;
   int             cycle_count = 0;
   bit             grow_mode;

   positional_list_stack_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // idle cycles before a transaction, with stretches of back-to-back traffic
   function automatic int draw_gap(inout bit calm);
      if ($urandom_range(0, 39) == 0) calm = !calm;
      return calm ? 0 : $urandom_range(0, 17);
   endfunction

   // one request transaction, called and returning at a falling edge
   task automatic send_request(input logic [FUNC_W-1:0] op, input logic [POS_W-1:0] pos,
                               input logic [VAL_W-1:0] value);
      int gap;
      gap = draw_gap(calm_req);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, value, pos};
      req_tuser  <= op;
      do @(posedge clock); while (!req_tready);
      list_sb.note_request(op, pos, value);
      @(negedge clock);
   endtask

   // hold the sender until every response is back
   task automatic drain_responses();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (list_sb.pending() != 0);
   endtask

   // mostly plain random words, sometimes the extremes
   function automatic logic [VAL_W-1:0] draw_value();
      case ($urandom_range(0, 19))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'hffff_ffff;
         3: return 32'h0000_0000;
         default: return $urandom;
      endcase
   endfunction

   // random request steered toward growth or shrinkage
   task automatic send_random();
      int n;
      int pick;
      logic [FUNC_W-1:0] op;
      logic [POS_W-1:0]  pos;
      n = list_sb.depth();
      // turn around a few requests after reaching full or empty
      if (grow_mode && n == LIST_DEPTH && $urandom_range(0, 2) == 0) grow_mode = 1'b0;
      else if (!grow_mode && n == 0 && $urandom_range(0, 2) == 0) grow_mode = 1'b1;
      pick = $urandom_range(0, 99);
      pos  = '0;
      if (pick < 40)      op = grow_mode ? FUNC_PUSH : FUNC_POP;
      else if (pick < 70) op = grow_mode ? FUNC_INSERT : FUNC_DELETE;
      else if (pick < 78) op = grow_mode ? FUNC_POP : FUNC_PUSH;
      else if (pick < 86) op = grow_mode ? FUNC_DELETE : FUNC_INSERT;
      else if (pick < 93) op = FUNC_TOP;
      else if (pick < 97) op = ($urandom_range(0, 1) != 0) ? FUNC_INSERT : FUNC_DELETE;
      else                op = FUNC_SPARE_5 + FUNC_W'($urandom_range(0, 2));
      if (pick >= 93 && pick < 97) pos = POS_W'($urandom_range(0, LIST_DEPTH));
      else if (op == FUNC_INSERT) pos = POS_W'($urandom_range(0, n));
      else if (op == FUNC_DELETE) pos = (n > 0) ? POS_W'($urandom_range(0, n - 1)) : '0;
      else pos = POS_W'($urandom_range(0, LIST_DEPTH));
      send_request(op, pos, draw_value());
   endtask

   // response side: random stalls, check on every handshake
   initial begin
      list_result_type got;
      int stall;
      wait (!reset);
      @(negedge clock);
      forever begin
         stall = draw_gap(calm_rsp);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         got.status      = rsp_tuser;
         got.top_value   = rsp_tdata[31:0];
         got.entry_count = rsp_tdata[38:32];
         got.is_empty    = rsp_tdata[39];
         list_sb.check_response(got);
         @(negedge clock);
      end
   end

   // reset, directed corner cases, random traffic, end of run
   initial begin
      grow_mode   = 1'b1;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // empty list corners
      send_request(FUNC_TOP,    7'd0,  32'h1234_5678);
      send_request(FUNC_POP,    7'd0,  32'h0);
      send_request(FUNC_DELETE, 7'd0,  32'h0);
      send_request(FUNC_DELETE, 7'd1,  32'h0);
      send_request(FUNC_INSERT, 7'd1,  32'hdead_beef);
      // fill a few entries: front, tail, middle, end
      send_request(FUNC_INSERT, 7'd0,  32'h8000_0000);
      send_request(FUNC_PUSH,   7'd0,  32'h7fff_ffff);
      send_request(FUNC_INSERT, 7'd1,  32'hffff_ffff);
      send_request(FUNC_INSERT, 7'd3,  32'h0000_0000);
      // positions past the end and at the count
      send_request(FUNC_INSERT, 7'd64, 32'h5a5a_5a5a);
      send_request(FUNC_DELETE, 7'd4,  32'h0);
      send_request(FUNC_DELETE, 7'd5,  32'h0);
      send_request(FUNC_DELETE, 7'd1,  32'h0);
      send_request(FUNC_DELETE, 7'd2,  32'h0);
      send_request(FUNC_TOP,    7'd0,  32'h0);
      // unused codes change nothing
      send_request(FUNC_SPARE_5, 7'd0,  32'hffff_ffff);
      send_request(FUNC_SPARE_6, 7'd64, 32'h0);
      send_request(FUNC_SPARE_7, 7'd1,  32'h1);
      send_request(FUNC_POP,    7'd0,  32'h0);
      send_request(FUNC_DELETE, 7'd0,  32'h0);
      send_request(FUNC_PUSH,   7'd0,  32'h5555_aaaa);
      send_request(FUNC_PUSH,   7'd0,  32'haaaa_5555);
      send_request(FUNC_POP,    7'd0,  32'h0);
      send_request(FUNC_POP,    7'd0,  32'h0);
      drain_responses();

      for (int i = 0; i < RANDOM_OPS; i++) begin
         if ($urandom_range(0, 59) == 0) drain_responses();
         send_random();
      end

      req_tvalid <= 1'b0;
      while (list_sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYC) @(posedge clock);
      if (list_sb.errors == 0 && list_sb.pending() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

FILE: filelist.f
hdl/pls_pkg.sv
hdl/pls_ctrl.sv
hdl/pls_dpath.sv
hdl/positional_list_stack_unit.sv
dv/tb.sv
